FILE: rtl/pli_pkg.sv
// shared types and constants for the piecewise linear interpolator
package pli_pkg;

    // input command codes
    typedef enum logic {
        t_cmd_load = 1'b0,
        t_cmd_eval = 1'b1
    } t_cmd;

    // configuration register addresses (byte)
    localparam logic [2:0] ADDR_POINTS_IN_USE = 3'd0;

    localparam int COORD_W = 32;
    localparam int SEG_W   = 4;
    localparam int CNT_W   = 5;

    // search result handed from the search stage to the divider
    typedef struct packed {
        logic oor;
        logic at_first;
    } t_seg_flags;

endpackage

FILE: rtl/pli_search.sv
// knot table with parallel compare and first-hit search, two register stages
module pli_search #(
    parameter int TABLE_POINTS = 16,
    parameter int IDX_W        = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_load,
    input  logic [IDX_W-1:0]            i_load_idx,
    input  logic signed [31:0]          i_load_x,
    input  logic signed [31:0]          i_load_y,
    input  logic                        i_valid,
    input  logic signed [31:0]          i_query,
    input  logic [4:0]                  i_points,
    output logic                        o_valid,
    output logic signed [31:0]          o_query,
    output logic signed [31:0]          o_x0,
    output logic signed [31:0]          o_x1,
    output logic signed [31:0]          o_y0,
    output logic signed [31:0]          o_y1,
    output logic [IDX_W-1:0]            o_seg,
    output pli_pkg::t_seg_flags         o_flags
);
    import pli_pkg::*;

    localparam int N_W = $clog2(TABLE_POINTS + 1);

    logic signed [31:0] r_kx [TABLE_POINTS];
    logic signed [31:0] r_ky [TABLE_POINTS];

    // stage a: compare vector
    logic                    r_a_valid;
    logic signed [31:0]      r_a_query;
    logic [TABLE_POINTS-1:0] r_a_hit;
    logic [N_W-1:0]          r_a_n;
    logic [TABLE_POINTS-1:0] n_hit;
    logic [N_W-1:0]          n_n;

    // clamp register to 1..TABLE_POINTS
    always_comb begin
        if (i_points == 5'd0) begin
            n_n = N_W'(1);
        end else if (32'(i_points) > TABLE_POINTS) begin
            n_n = N_W'(TABLE_POINTS);
        end else begin
            n_n = N_W'(i_points);
        end
        for (int k = 0; k < TABLE_POINTS; k++) begin
            n_hit[k] = (i_query <= r_kx[k]) && (k < 32'(n_n));
        end
    end

    // knot writes
    always_ff @(posedge i_clk) begin
        if (i_load && (32'(i_load_idx) < TABLE_POINTS)) begin
            r_kx[i_load_idx] <= i_load_x;
            r_ky[i_load_idx] <= i_load_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_query <= i_query;
            r_a_hit   <= n_hit;
            r_a_n     <= n_n;
        end
    end

    // stage b: priority pick and knot fetch
    logic [IDX_W-1:0] n_seg;
    logic             n_found;
    always_comb begin
        n_seg   = IDX_W'(r_a_n - N_W'(1));
        n_found = 1'b0;
        for (int k = TABLE_POINTS - 1; k >= 0; k--) begin
            if (r_a_hit[k]) begin
                n_seg   = IDX_W'(k);
                n_found = 1'b1;
            end
        end
    end

    logic [IDX_W-1:0] w_lo;
    assign w_lo = (n_seg == '0) ? '0 : n_seg - IDX_W'(1);

    logic                r_b_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_query           <= r_a_query;
            o_x0              <= r_kx[w_lo];
            o_x1              <= r_kx[n_seg];
            o_y0              <= r_ky[w_lo];
            o_y1              <= r_ky[n_seg];
            o_seg             <= n_seg;
            o_flags.oor       <= !n_found;
            o_flags.at_first  <= n_found && (n_seg == '0);
        end
    end

    assign o_valid = r_b_valid;

endmodule

FILE: rtl/pli_div.sv
// pipelined restoring divider, one quotient bit per stage, payload rides along
module pli_div #(
    parameter int FRAC_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [32:0]           i_num,
    input  logic [32:0]           i_den,
    input  logic signed [31:0]    i_y0,
    input  logic signed [31:0]    i_y1,
    input  logic [IDX_W-1:0]      i_seg,
    input  pli_pkg::t_seg_flags   i_flags,
    output logic                  o_valid,
    output logic [FRAC_BITS:0]    o_t,
    output logic signed [31:0]    o_y0,
    output logic signed [31:0]    o_y1,
    output logic [IDX_W-1:0]      o_seg,
    output pli_pkg::t_seg_flags   o_flags
);
    import pli_pkg::*;

    // num < den here so quotient of num*2^F fits in F bits; F steps of one bit
    localparam int ST = FRAC_BITS;

    logic                 r_v   [ST+1];
    logic [33:0]          r_rem [ST+1];
    logic [32:0]          r_den [ST+1];
    logic [FRAC_BITS:0]   r_q   [ST+1];
    logic signed [31:0]   r_y0  [ST+1];
    logic signed [31:0]   r_y1  [ST+1];
    logic [IDX_W-1:0]     r_seg [ST+1];
    t_seg_flags           r_fl  [ST+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, i_num};
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_y0[0]  <= i_y0;
            r_y1[0]  <= i_y1;
            r_seg[0] <= i_seg;
            r_fl[0]  <= i_flags;
        end
    end

    for (genvar s = 0; s < ST; s++) begin : g_stage
        logic [34:0] w_sh;
        logic        w_ge;
        assign w_sh = {r_rem[s], 1'b0};
        assign w_ge = w_sh >= {2'b00, r_den[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? 34'(w_sh - {2'b00, r_den[s]}) : 34'(w_sh);
                r_q[s+1]   <= {r_q[s][FRAC_BITS-1:0], w_ge};
                r_den[s+1] <= r_den[s];
                r_y0[s+1]  <= r_y0[s];
                r_y1[s+1]  <= r_y1[s];
                r_seg[s+1] <= r_seg[s];
                r_fl[s+1]  <= r_fl[s];
            end
        end
    end

    // num == den (t = one) is flagged beside the divider by the top level
    assign o_valid = r_v[ST];
    assign o_t     = r_q[ST];
    assign o_y0    = r_y0[ST];
    assign o_y1    = r_y1[ST];
    assign o_seg   = r_seg[ST];
    assign o_flags = r_fl[ST];

endmodule

FILE: rtl/pli_lerp.sv
// weighted blend of y0 and y1: two multiplies, sum, floor shift, or y1 as is
module pli_lerp #(
    parameter int FRAC_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [FRAC_BITS:0]    i_t,
    input  logic signed [31:0]    i_y0,
    input  logic signed [31:0]    i_y1,
    input  logic [IDX_W-1:0]      i_seg,
    input  pli_pkg::t_seg_flags   i_flags,
    output logic                  o_valid,
    output logic signed [31:0]    o_y,
    output logic [IDX_W-1:0]      o_seg,
    output logic                  o_oor
);
    import pli_pkg::*;

    localparam int PW = 32 + FRAC_BITS + 2;
    localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS + 2)'(1) << FRAC_BITS;

    // product stage
    logic                 r_v;
    logic signed [PW-1:0] r_p0, r_p1;
    logic signed [31:0]   r_ysel;
    logic                 r_pass;
    logic [IDX_W-1:0]     r_seg;
    logic                 r_oor;

    logic signed [FRAC_BITS+1:0] w_w0, w_w1;
    assign w_w1 = $signed({1'b0, i_t});
    assign w_w0 = $signed(ONE - {1'b0, i_t});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
            o_valid <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0   <= PW'(i_y0 * w_w0);
            r_p1   <= PW'(i_y1 * w_w1);
            r_pass <= i_flags.oor || i_flags.at_first;
            r_ysel <= i_y1;
            r_seg  <= i_seg;
            r_oor  <= i_flags.oor;
        end
    end

    // sum and arithmetic shift (floor)
    logic signed [PW-1:0] w_sum;
    assign w_sum = r_p0 + r_p1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_y   <= r_pass ? r_ysel : 32'(w_sum >>> FRAC_BITS);
            o_seg <= r_seg;
            o_oor <= r_oor;
        end
    end

endmodule

FILE: rtl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a loadable knot table, Q16.16 signed.
// Fully pipelined: one word accepted per cycle unless the output stalls; the
// stages are compare, pick/fetch, subtract, divider load, FRAC_BITS divider
// stages, multiply and sum. The one-bit-per-stage divider sets the depth. A
// stall on the output holds the whole pipeline. Loads write the table at
// acceptance and give no word out; queries above the last knot return its y
// with out_of_range set.
module piecewise_linear_interpolator #(
    parameter int TABLE_POINTS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input: tuser = command; tdata = entry_index[3:0], entry_x[35:4],
    // entry_y[67:36], query_x[99:68], zero pad to 104
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    // output: tdata = value_y[31:0], segment_index[35:32], out_of_range[36], pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata
);
    import pli_pkg::*;

    localparam int IDX_W = 4;

    logic [CNT_W-1:0] r_points;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= CNT_W'(1);
        end else if (psel && penable && pwrite && paddr == ADDR_POINTS_IN_USE) begin
            r_points <= pwdata[CNT_W-1:0];
        end
    end
    assign prdata = (paddr == ADDR_POINTS_IN_USE) ? {27'd0, r_points} : 32'd0;

    // pipeline advances unless a held output word is blocked
    logic w_en;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    logic w_acc;
    assign w_acc = s_axis_tvalid && w_en;

    logic               w_load, w_eval;
    assign w_load = w_acc && (t_cmd'(s_axis_tuser) == t_cmd_load);
    assign w_eval = w_acc && (t_cmd'(s_axis_tuser) == t_cmd_eval);

    logic                sv;
    logic signed [31:0]  sq, sx0, sx1, sy0, sy1;
    logic [IDX_W-1:0]    sseg;
    t_seg_flags          sfl;

    pli_search #(.TABLE_POINTS(TABLE_POINTS), .IDX_W(IDX_W)) u_search (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_load(w_load), .i_load_idx(s_axis_tdata[3:0]),
        .i_load_x(s_axis_tdata[35:4]), .i_load_y(s_axis_tdata[67:36]),
        .i_valid(w_eval), .i_query(s_axis_tdata[99:68]), .i_points(r_points),
        .o_valid(sv), .o_query(sq), .o_x0(sx0), .o_x1(sx1), .o_y0(sy0),
        .o_y1(sy1), .o_seg(sseg), .o_flags(sfl)
    );

    // differences; num <= den, the equal case (t = one) is flagged beside
    // the divider
    logic                r_dv;
    logic [32:0]         r_num, r_den;
    logic signed [31:0]  r_y0, r_y1;
    logic [IDX_W-1:0]    r_seg;
    t_seg_flags          r_fl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (w_en) begin
            r_dv <= sv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num <= 33'({sq[31], sq} - {sx0[31], sx0});
            r_den <= 33'({sx1[31], sx1} - {sx0[31], sx0});
            r_y0  <= sy0;
            r_y1  <= sy1;
            r_seg <= sseg;
            r_fl  <= sfl;
        end
    end

    logic                dv;
    logic [FRAC_BITS:0]  dt;
    logic signed [31:0]  dy0, dy1;
    logic [IDX_W-1:0]    dseg;
    t_seg_flags          dfl;
    logic                w_eq;
    logic [FRAC_BITS:0]  w_t;
    logic                r_eq [FRAC_BITS+1];

    // exact upper knot: quotient is exactly one, tracked beside the divider
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_eq[0] <= (r_num == r_den);
            for (int k = 1; k <= FRAC_BITS; k++) begin
                r_eq[k] <= r_eq[k-1];
            end
        end
    end
    assign w_eq = r_eq[FRAC_BITS];

    pli_div #(.FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W)) u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r_dv),
        .i_num(r_num), .i_den(r_den), .i_y0(r_y0), .i_y1(r_y1),
        .i_seg(r_seg), .i_flags(r_fl),
        .o_valid(dv), .o_t(dt), .o_y0(dy0), .o_y1(dy1), .o_seg(dseg), .o_flags(dfl)
    );
    assign w_t = w_eq ? ((FRAC_BITS + 1)'(1) << FRAC_BITS) : dt;

    logic signed [31:0] ly;
    logic [IDX_W-1:0]   lseg;
    logic               loor;
    pli_lerp #(.FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W)) u_lerp (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(dv), .i_t(w_t),
        .i_y0(dy0), .i_y1(dy1), .i_seg(dseg), .i_flags(dfl),
        .o_valid(m_axis_tvalid), .o_y(ly), .o_seg(lseg), .o_oor(loor)
    );

    assign m_axis_tdata = {3'd0, loor, lseg, ly};

endmodule

FILE: rtl/pli_checker.sv
// port-level checks for the interpolator, bound to the top level
module pli_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        s_axis_tready,
    input logic        pready
);
    // a held output word does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // input is ready whenever the output holds no word
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // nothing valid straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // apb never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .s_axis_tready, .pready
);
